@@ rtl/ufcd_pkg.sv @@
// Shared constants, types and helpers for the union-find cycle detector.
`default_nettype none

package ufcd_pkg;

    localparam int VERTEX_W        = 8;
    localparam int MAX_VERTICES_DEF = 256;
    localparam int QUEUE_DEPTH     = 2;
    // Fraction bits of the reciprocal used for the vertex index reduction
    localparam int RECIP_SHIFT     = 24;

    // One edge after index reduction, as it sits in the queue
    typedef struct packed {
        logic [VERTEX_W-1:0] src_vertex;
        logic [VERTEX_W-1:0] dest_vertex;
        logic                last_edge;
    } edge_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_ROOT,
        B_ROOT_WAIT,
        B_COMPRESS,
        B_COMPRESS_WAIT,
        B_LINK
    } back_state_t;

    // Only vertex numbers that fit the input field can ever be touched
    function automatic int store_depth(input int max_vertices);
        return (max_vertices < 2**VERTEX_W) ? max_vertices : 2**VERTEX_W;
    endfunction

endpackage

`default_nettype wire

@@ rtl/ufcd_if.sv @@
// Channel interfaces: edge input and verdict output.
`default_nettype none

interface ufcd_edge_if;
    logic                          valid;
    logic                          ready;
    logic [ufcd_pkg::VERTEX_W-1:0] src_vertex;
    logic [ufcd_pkg::VERTEX_W-1:0] dest_vertex;
    logic                          last_edge;

    modport source (output valid, output src_vertex, output dest_vertex,
                    output last_edge, input ready);
    modport sink   (input valid, input src_vertex, input dest_vertex,
                    input last_edge, output ready);
endinterface

interface ufcd_verdict_if;
    logic valid;
    logic ready;
    logic cycle_now;
    logic cycle_seen;
    logic graph_done;

    modport source (output valid, output cycle_now, output cycle_seen,
                    output graph_done, input ready);
    modport sink   (input valid, input cycle_now, input cycle_seen,
                    input graph_done, output ready);
endinterface

`default_nettype wire

@@ rtl/ufcd_front.sv @@
// Front end: accepts edges and reduces vertex numbers modulo the store depth.
`default_nettype none

module ufcd_front #(
    parameter int STORE_DEPTH = ufcd_pkg::MAX_VERTICES_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    ufcd_edge_if.sink             edge_in,
    output logic                  push_valid,
    output ufcd_pkg::edge_t       push_data,
    input  wire logic             push_ready
);

    localparam int VW       = ufcd_pkg::VERTEX_W;
    localparam int RShift   = ufcd_pkg::RECIP_SHIFT;
    localparam int ProdW    = VW + RShift + 1;
    localparam int BackW    = 2 * VW + 1;
    // ceil(2^RShift / depth): exact quotient for every 8-bit value
    localparam logic [RShift:0] Recip =
        (RShift+1)'((2**RShift + STORE_DEPTH - 1) / STORE_DEPTH);

    logic          s1_valid_reg;
    logic [VW-1:0] s1_src_reg, s1_dest_reg;
    logic [VW-1:0] s1_qs_reg,  s1_qd_reg;
    logic          s1_last_reg;
    logic          s2_valid_reg;
    ufcd_pkg::edge_t s2_entry_reg;

    logic          s2_move, s1_move, in_fire;
    logic [ProdW-1:0] mul_src, mul_dest;
    logic [BackW-1:0] back_src, back_dest;
    logic [VW:0]      rem_src, rem_dest;

    assign s2_move       = !s2_valid_reg || push_ready;
    assign s1_move       = !s1_valid_reg || s2_move;
    assign edge_in.ready = s1_move;
    assign in_fire       = edge_in.valid && s1_move;

    // stage 1: quotient by reciprocal multiply
    assign mul_src  = ProdW'(edge_in.src_vertex)  * ProdW'(Recip);
    assign mul_dest = ProdW'(edge_in.dest_vertex) * ProdW'(Recip);

    // stage 2: remainder = value - quotient * depth
    assign back_src  = BackW'(s1_qs_reg) * BackW'(STORE_DEPTH);
    assign back_dest = BackW'(s1_qd_reg) * BackW'(STORE_DEPTH);
    assign rem_src   = (VW+1)'(s1_src_reg)  - back_src[VW:0];
    assign rem_dest  = (VW+1)'(s1_dest_reg) - back_dest[VW:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_move)
                s1_valid_reg <= edge_in.valid;
            if (s2_move)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_src_reg  <= edge_in.src_vertex;
            s1_dest_reg <= edge_in.dest_vertex;
            s1_qs_reg   <= mul_src[RShift +: VW];
            s1_qd_reg   <= mul_dest[RShift +: VW];
            s1_last_reg <= edge_in.last_edge;
        end
        if (s2_move && s1_valid_reg)
        begin
            s2_entry_reg.src_vertex  <= rem_src[VW-1:0];
            s2_entry_reg.dest_vertex <= rem_dest[VW-1:0];
            s2_entry_reg.last_edge   <= s1_last_reg;
        end
    end

    assign push_valid = s2_valid_reg;
    assign push_data  = s2_entry_reg;

endmodule

`default_nettype wire

@@ rtl/ufcd_queue.sv @@
// Small FIFO between the front end and the union-find engine.
`default_nettype none

module ufcd_queue #(
    parameter int WIDTH = $bits(ufcd_pkg::edge_t),
    parameter int DEPTH = ufcd_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  push_ready,
    output logic                  pop_valid,
    output logic [WIDTH-1:0]      pop_data,
    input  wire logic             pop_ready
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LastPtr = PW'(DEPTH - 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             push_fire, pop_fire;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_fire)
                wr_ptr_reg <= (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
            if (pop_fire)
                rd_ptr_reg <= (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
            if (push_fire && !pop_fire)
                count_reg <= count_reg + 1'b1;
            else if (pop_fire && !push_fire)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

@@ rtl/ufcd_back.sv @@
// Union-find engine: root walks, path compression, link and verdict register.
`default_nettype none

module ufcd_back #(
    parameter int STORE_DEPTH = ufcd_pkg::MAX_VERTICES_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            pop_valid,
    input  wire ufcd_pkg::edge_t pop_data,
    output logic                 pop_ready,
    ufcd_verdict_if.source       verdict_out
);

    localparam int IW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    ufcd_pkg::back_state_t state_reg, state_next;

    // parent store: written only on link or compression, read where linked
    logic [IW-1:0] parent_mem [STORE_DEPTH];
    logic [IW-1:0] rd_data_reg;
    logic          mem_re, mem_we;
    logic [IW-1:0] rd_addr, wr_addr, wr_data;

    logic [STORE_DEPTH-1:0] hp_reg, hp_next;
    logic                   cycle_flag_reg, cycle_flag_next;

    logic [IW-1:0] b_reg, b_next;
    logic          last_reg, last_next;
    logic [IW-1:0] node_reg, node_next;
    logic [IW-1:0] cur_reg, cur_next;
    logic [IW-1:0] root_reg, root_next;
    logic [IW-1:0] ra_reg, ra_next;
    logic [IW-1:0] rb_reg, rb_next;
    logic          which_reg, which_next;

    logic out_valid_reg, out_valid_next;
    logic out_now_reg, out_now_next;
    logic out_seen_reg, out_seen_next;
    logic out_done_reg, out_done_next;

    logic out_free, link_fire, walk_more, root_more;

    assign out_free  = !out_valid_reg || verdict_out.ready;
    assign link_fire = (state_reg == ufcd_pkg::B_LINK) && out_free;
    assign root_more = hp_reg[node_reg];
    assign walk_more = (cur_reg != root_reg) && hp_reg[cur_reg];
    assign pop_ready = (state_reg == ufcd_pkg::B_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ufcd_pkg::B_IDLE:
            begin
                if (pop_valid)
                    state_next = cycle_flag_reg ? ufcd_pkg::B_LINK : ufcd_pkg::B_ROOT;
            end
            ufcd_pkg::B_ROOT:
                state_next = root_more ? ufcd_pkg::B_ROOT_WAIT : ufcd_pkg::B_COMPRESS;
            ufcd_pkg::B_ROOT_WAIT:
                state_next = ufcd_pkg::B_ROOT;
            ufcd_pkg::B_COMPRESS:
            begin
                if (walk_more)
                    state_next = ufcd_pkg::B_COMPRESS_WAIT;
                else
                    state_next = which_reg ? ufcd_pkg::B_LINK : ufcd_pkg::B_ROOT;
            end
            ufcd_pkg::B_COMPRESS_WAIT:
                state_next = ufcd_pkg::B_COMPRESS;
            ufcd_pkg::B_LINK:
            begin
                if (out_free)
                    state_next = ufcd_pkg::B_IDLE;
            end
            default:
                state_next = ufcd_pkg::B_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        hp_next         = hp_reg;
        cycle_flag_next = cycle_flag_reg;
        b_next          = b_reg;
        last_next       = last_reg;
        node_next       = node_reg;
        cur_next        = cur_reg;
        root_next       = root_reg;
        ra_next         = ra_reg;
        rb_next         = rb_reg;
        which_next      = which_reg;
        out_valid_next  = out_valid_reg && !verdict_out.ready;
        out_now_next    = out_now_reg;
        out_seen_next   = out_seen_reg;
        out_done_next   = out_done_reg;
        mem_re          = 1'b0;
        mem_we          = 1'b0;
        rd_addr         = cur_reg;
        wr_addr         = cur_reg;
        wr_data         = root_reg;

        case (state_reg)
            ufcd_pkg::B_IDLE:
            begin
                if (pop_valid)
                begin
                    b_next     = pop_data.dest_vertex[IW-1:0];
                    last_next  = pop_data.last_edge;
                    node_next  = pop_data.src_vertex[IW-1:0];
                    cur_next   = pop_data.src_vertex[IW-1:0];
                    which_next = 1'b0;
                end
            end
            ufcd_pkg::B_ROOT:
            begin
                if (root_more)
                begin
                    mem_re  = 1'b1;
                    rd_addr = node_reg;
                end
                else
                    root_next = node_reg;
            end
            ufcd_pkg::B_ROOT_WAIT:
                node_next = rd_data_reg;
            ufcd_pkg::B_COMPRESS:
            begin
                if (walk_more)
                    mem_re = 1'b1;
                else if (!which_reg)
                begin
                    ra_next    = root_reg;
                    which_next = 1'b1;
                    node_next  = b_reg;
                    cur_next   = b_reg;
                end
                else
                    rb_next = root_reg;
            end
            ufcd_pkg::B_COMPRESS_WAIT:
            begin
                // point this path vertex at the root, step to its old parent
                mem_we   = 1'b1;
                cur_next = rd_data_reg;
            end
            ufcd_pkg::B_LINK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_done_next  = last_reg;
                    if (cycle_flag_reg)
                    begin
                        out_now_next  = 1'b0;
                        out_seen_next = 1'b1;
                    end
                    else if (ra_reg == rb_reg)
                    begin
                        out_now_next    = 1'b1;
                        out_seen_next   = 1'b1;
                        cycle_flag_next = 1'b1;
                    end
                    else
                    begin
                        out_now_next    = 1'b0;
                        out_seen_next   = 1'b0;
                        mem_we          = 1'b1;
                        wr_addr         = ra_reg;
                        wr_data         = rb_reg;
                        hp_next[ra_reg] = 1'b1;
                    end
                    if (last_reg)
                    begin
                        hp_next         = '0;
                        cycle_flag_next = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ufcd_pkg::B_IDLE;
            hp_reg         <= '0;
            cycle_flag_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            hp_reg         <= hp_next;
            cycle_flag_reg <= cycle_flag_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg        <= b_next;
        last_reg     <= last_next;
        node_reg     <= node_next;
        cur_reg      <= cur_next;
        root_reg     <= root_next;
        ra_reg       <= ra_next;
        rb_reg       <= rb_next;
        which_reg    <= which_next;
        out_now_reg  <= out_now_next;
        out_seen_reg <= out_seen_next;
        out_done_reg <= out_done_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            parent_mem[wr_addr] <= wr_data;
        if (mem_re)
            rd_data_reg <= parent_mem[rd_addr];
    end

    assign verdict_out.valid      = out_valid_reg;
    assign verdict_out.cycle_now  = out_now_reg;
    assign verdict_out.cycle_seen = out_seen_reg;
    assign verdict_out.graph_done = out_done_reg;

    // forest is frozen once a cycle is known
    a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        cycle_flag_reg |-> !mem_we)
        else $error("parent store written after cycle found");

    // end of graph empties the forest and the flag
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (link_fire && last_reg) |=> (hp_reg == '0 && !cycle_flag_reg))
        else $error("store not cleared after last edge");

    // compression walks toward a true root
    a_root: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ufcd_pkg::B_COMPRESS) |-> !hp_reg[root_reg])
        else $error("compression target is not a root");

    // link only hangs a root under another root
    a_link: assert property (@(posedge clk) disable iff (!rst_n)
        (link_fire && !cycle_flag_reg && ra_reg != rb_reg)
            |-> (!hp_reg[ra_reg] && !hp_reg[rb_reg]))
        else $error("link of a non-root vertex");

endmodule

`default_nettype wire

@@ rtl/union_find_cycle_detect_top.sv @@
// Top level of the union-find cycle detector with path compression.
//
//  channel      dir  handshake      payload
//  edge_in      in   valid/ready    src_vertex[7:0] dest_vertex[7:0] last_edge
//  verdict_out  out  valid/ready    cycle_now cycle_seen graph_done
//
// An edge passes the front end registers (quotient, then remainder) and a
// two-entry queue. The engine takes no new edge until idle: it walks to the
// root of each end and compresses that path (registered parent reads), then
// links; with the cycle flag set it goes from idle straight to link.
// Reset empties the forest and the cycle flag at once; no clearing pass.
// A stalled verdict register holds the engine; front end and queue fill up.
`default_nettype none

module union_find_cycle_detect_top #(
    parameter int MAX_VERTICES = ufcd_pkg::MAX_VERTICES_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    ufcd_edge_if.sink      edge_in,
    ufcd_verdict_if.source verdict_out
);

    // vertices beyond the field range are never reached
    localparam int StoreDepth = ufcd_pkg::store_depth(MAX_VERTICES);

    logic            push_valid, push_ready;
    ufcd_pkg::edge_t push_data;
    logic            pop_valid, pop_ready;
    ufcd_pkg::edge_t pop_data;
    logic [$bits(ufcd_pkg::edge_t)-1:0] pop_bits;

    ufcd_front #(
        .STORE_DEPTH (StoreDepth)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .edge_in    (edge_in),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    ufcd_queue #(
        .WIDTH ($bits(ufcd_pkg::edge_t)),
        .DEPTH (ufcd_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_bits),
        .pop_ready  (pop_ready)
    );

    assign pop_data = ufcd_pkg::edge_t'(pop_bits);

    ufcd_back #(
        .STORE_DEPTH (StoreDepth)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_data    (pop_data),
        .pop_ready   (pop_ready),
        .verdict_out (verdict_out)
    );

endmodule

`default_nettype wire

@@ verif/union_find_cycle_detect_top_test.sv @@
// Self-checking testbench for the union-find cycle detector: directed and random edge streams.
`default_nettype none

module union_find_cycle_detect_top_test;

    // Vertex count of the default build; vertex numbers reduce modulo this.
    localparam int NV = ufcd_pkg::MAX_VERTICES_DEF;

    // Watchdog limit: above the worst engine time for a graph edge (both root
    // walks and both compressions at full chain length) plus the front end, the
    // queue and the longest receiver stall.
    localparam int STALL_LIMIT = 20000;

    // Quiet time after the last verdict, long enough to catch a stray transfer.
    localparam int TAIL_CYCLES = 100;

    localparam int ITEM_TARGET = 950;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic cycle_now;
        logic cycle_seen;
        logic graph_done;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n;

    ufcd_edge_if    edge_ch ();
    ufcd_verdict_if verdict_ch ();

    union_find_cycle_detect_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .edge_in    (edge_ch),
        .verdict_out(verdict_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: the disjoint-set forest and the sticky cycle flag.
    // forest_parent is only read where forest_linked is set.
    // ------------------------------------------------------------------
    int       forest_parent [NV];
    bit       forest_linked [NV];
    bit       graph_has_cycle;

    verdict_t expected_verdicts [$];

    int       edges_sent;
    int       verdict_mismatches;
    int       stall_cycles;
    bit       idle_on;              // 0: both sides run with no gaps at all

    // Walk to the root, then point every vertex on the walked path at it.
    function automatic int root_of(input int v);
        int r;
        int steps;
        int cur;
        int nxt;
        r = v;
        steps = 0;
        while (forest_linked[r] && steps < NV)
        begin
            r = forest_parent[r] % NV;
            steps++;
        end
        cur = v;
        steps = 0;
        while (cur != r && forest_linked[cur] && steps < NV)
        begin
            nxt = forest_parent[cur] % NV;
            forest_parent[cur] = r;
            cur = nxt;
            steps++;
        end
        return r;
    endfunction

    // Verdict for the given edge; updates the forest unless the cycle flag is
    // set. The last edge of a graph clears links and flag afterwards.
    function automatic verdict_t predict_verdict(input logic [7:0] s, input logic [7:0] d,
                                                 input logic last);
        verdict_t vr;
        int       ra;
        int       rb;
        vr = '0;
        if (!graph_has_cycle)
        begin
            ra = root_of(int'(s) % NV);
            rb = root_of(int'(d) % NV);
            if (ra == rb)
            begin
                vr.cycle_now = 1'b1;
                graph_has_cycle = 1'b1;
            end
            else
            begin
                forest_parent[ra] = rb;
                forest_linked[ra] = 1'b1;
            end
        end
        vr.cycle_seen = graph_has_cycle;
        vr.graph_done = last;
        if (last)
        begin
            foreach (forest_linked[i])
                forest_linked[i] = 1'b0;
            graph_has_cycle = 1'b0;
        end
        return vr;
    endfunction

    // Mostly short gaps, a few long ones.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Edge sender. Called at a rising edge; returns at the edge of the
    // transfer with valid still high, so back-to-back edges never drop it.
    // ------------------------------------------------------------------
    task automatic send_edge(input int s, input int d, input bit last);
        int       g;
        verdict_t vr;
        g = idle_on ? gap_len() : 0;
        if (g > 0)
        begin
            edge_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        edge_ch.valid       <= 1'b1;
        edge_ch.src_vertex  <= 8'(s);
        edge_ch.dest_vertex <= 8'(d);
        edge_ch.last_edge   <= last;
        @(posedge clk);
        while (!edge_ch.ready)
            @(posedge clk);
        vr = predict_verdict(8'(s), 8'(d), last);
        expected_verdicts.push_back(vr);
        edges_sent++;
    endtask

    // Hold off the sender until every outstanding verdict is back.
    task automatic pause_until_drained();
        edge_ch.valid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
    endtask

    // One random graph. Most are well formed (a spanning tree, maybe closed
    // into a cycle, then a few ignored edges); the rest are chains, noise that
    // may run on into the next graph, and small crowded pools.
    task automatic send_random_graph();
        int  vtx [NV];
        int  kind;
        int  n;
        int  base;
        int  stride;
        int  a;
        int  b;
        int  t;
        int  extra;
        int  pool;
        bit  closing;
        bit  fin;
        kind   = $urandom_range(0, 9);
        base   = $urandom_range(0, NV - 1);
        stride = $urandom_range(0, NV / 2 - 1) * 2 + 1;     // odd: distinct vertices
        foreach (vtx[i])
            vtx[i] = (base + i * stride) % NV;
        if (kind <= 5)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(2, 12);
            closing = ($urandom_range(0, 2) != 0);
            for (int i = 1; i < n; i++)
            begin
                a = vtx[i];
                b = vtx[$urandom_range(0, i - 1)];
                if ($urandom_range(0, 1))
                begin
                    t = a;
                    a = b;
                    b = t;
                end
                send_edge(a, b, !closing && i == n - 1);
            end
            if (closing)
            begin
                // may pick the same vertex twice: a self loop
                extra = $urandom_range(0, 3);
                send_edge(vtx[$urandom_range(0, n - 1)], vtx[$urandom_range(0, n - 1)],
                          extra == 0);
                for (int j = 0; j < extra; j++)
                    send_edge($urandom_range(0, 255), $urandom_range(0, 255), j == extra - 1);
            end
        end
        else if (kind <= 7)
        begin
            // chain: every new link hangs the old root under the next vertex
            n = $urandom_range(3, 60);
            for (int i = 0; i < n - 1; i++)
                send_edge(vtx[i], vtx[i + 1], 1'b0);
            send_edge(vtx[0], vtx[n - 1], 1'b1);
        end
        else if (kind == 8)
        begin
            n   = $urandom_range(1, 15);
            fin = ($urandom_range(0, 1) != 0);
            for (int i = 0; i < n; i++)
                send_edge($urandom_range(0, 255), $urandom_range(0, 255),
                          ($urandom_range(0, 7) == 0) || (fin && i == n - 1));
        end
        else
        begin
            pool = $urandom_range(2, 8);
            n    = $urandom_range(2, 12);
            for (int i = 0; i < n; i++)
                send_edge((base + $urandom_range(0, pool - 1)) % NV,
                          (base + $urandom_range(0, pool - 1)) % NV, i == n - 1);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, self loops, edges once the cycle flag is set, last-edge clearing.
    task automatic test_directed();
        send_edge(0, 255, 1'b0);        // joins two roots
        send_edge(255, 0, 1'b0);        // same root: cycle
        send_edge(1, 1, 1'b0);          // ignored after the cycle
        send_edge(254, 254, 1'b1);      // ignored, ends the graph
        send_edge(0, 0, 1'b1);          // self loop on a fresh forest, alone in its graph
        send_edge(128, 127, 1'b1);      // single edge graph, no cycle
        send_edge(255, 0, 1'b1);        // forest was cleared: no cycle
        // triangle, then ignored edges
        send_edge(1, 2, 1'b0);
        send_edge(2, 3, 1'b0);
        send_edge(3, 1, 1'b0);
        send_edge(4, 5, 1'b0);
        send_edge(6, 7, 1'b1);
        // short chain; the closing edge walks and compresses it
        send_edge(10, 11, 1'b0);
        send_edge(11, 12, 1'b0);
        send_edge(12, 13, 1'b0);
        send_edge(13, 14, 1'b0);
        send_edge(10, 15, 1'b0);        // walks 10..14, links 14 under 15
        send_edge(11, 15, 1'b0);        // compressed path: cycle
        send_edge(170, 85, 1'b1);
    endtask

    // Longest possible chain over every vertex; the closing find walks all of it.
    task automatic test_long_chain();
        int vtx [NV];
        int base;
        int stride;
        base   = $urandom_range(0, NV - 1);
        stride = $urandom_range(0, NV / 2 - 1) * 2 + 1;
        foreach (vtx[i])
            vtx[i] = (base + i * stride) % NV;
        for (int i = 0; i < NV - 1; i++)
            send_edge(vtx[i], vtx[i + 1], 1'b0);
        send_edge(vtx[0], vtx[NV - 1], 1'b1);
    endtask

    // Sender waits for a full drain between graphs.
    task automatic test_drain_pause();
        for (int k = 0; k < 3; k++)
        begin
            send_random_graph();
            pause_until_drained();
        end
    endtask

    // Both sides at full rate.
    task automatic test_back_to_back(input int count);
        int stop_at;
        idle_on = 1'b0;
        stop_at = edges_sent + count;
        while (edges_sent < stop_at)
            send_random_graph();
        idle_on = 1'b1;
    endtask

    task automatic test_random_graphs(input int target);
        while (edges_sent < target)
            send_random_graph();
    endtask

    // ------------------------------------------------------------------
    // Verdict side: random backpressure, checker, watchdog
    // ------------------------------------------------------------------
    initial
    begin
        int g;
        verdict_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            verdict_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            g = idle_on ? gap_len() : 0;
            if (g > 0)
            begin
                verdict_ch.ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
    end

    // Each verdict transfer is matched against the oldest prediction.
    always @(posedge clk)
    begin
        verdict_t want;
        verdict_t got;
        if (rst_n && verdict_ch.valid && verdict_ch.ready)
        begin
            got = '{verdict_ch.cycle_now, verdict_ch.cycle_seen, verdict_ch.graph_done};
            if (expected_verdicts.size() == 0)
            begin
                verdict_mismatches++;
                if (verdict_mismatches <= MAX_REPORTS)
                    $display("ERROR: verdict with none pending: now=%b seen=%b done=%b",
                             got.cycle_now, got.cycle_seen, got.graph_done);
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (got.cycle_now !== want.cycle_now || got.cycle_seen !== want.cycle_seen ||
                    got.graph_done !== want.graph_done)
                begin
                    verdict_mismatches++;
                    if (verdict_mismatches <= MAX_REPORTS)
                        $display("ERROR: verdict mismatch: exp now=%b seen=%b done=%b",
                                 want.cycle_now, want.cycle_seen, want.graph_done,
                                 ", got now=%b seen=%b done=%b",
                                 got.cycle_now, got.cycle_seen, got.graph_done);
                end
            end
        end
    end

    // Any transfer on either channel restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (edge_ch.valid && edge_ch.ready) ||
            (verdict_ch.valid && verdict_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("ERROR: no transfer for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n               = 1'b0;
        idle_on             = 1'b1;
        edges_sent          = 0;
        verdict_mismatches  = 0;
        stall_cycles        = 0;
        graph_has_cycle     = 1'b0;
        edge_ch.valid       <= 1'b0;
        edge_ch.src_vertex  <= '0;
        edge_ch.dest_vertex <= '0;
        edge_ch.last_edge   <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_drain_pause();
        test_long_chain();
        test_back_to_back(120);
        test_random_graphs(ITEM_TARGET);

        edge_ch.valid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (verdict_mismatches == 0 && expected_verdicts.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
